[design/srks_pkg.sv]
// Shared types and opcodes for the sequence ring with keyframe search.
// Used by the ring memory and the top level; depends on nothing.
package srks_pkg;

	localparam logic [2:0] OP_PUSH     = 3'd0;
	localparam logic [2:0] OP_READ     = 3'd1;
	localparam logic [2:0] OP_FIND_KEY = 3'd2;
	localparam logic [2:0] OP_MARK_GOP = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] entry_handle;
		logic        entry_is_key;
		logic [31:0] position_index;
	} srks_req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] handle_out;
		logic        key_out;
		logic        stale;
		logic [31:0] write_position;
		logic [31:0] oldest_position;
		logic [31:0] key_start;
		logic [31:0] gop_mark;
	} srks_rsp_t;

	// one ring slot: fragment handle and its keyframe flag
	typedef struct packed {
		logic [31:0] handle;
		logic        is_key;
	} srks_entry_t;

endpackage

[design/srks_ring_mem.sv]
// Ring slot storage: one write port, one read port with registered read data.
// Depends on srks_pkg for the slot entry type.
module srks_ring_mem import srks_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  srks_entry_t   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output srks_entry_t   rd_data
);

	srks_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[design/sequence_ring_with_keyframe_search.sv]
// Sequence-numbered fragment ring with keyframe search (top level).
// The result strobe (done) comes in the cycle after a request is taken.
// A new request is not taken while busy; busy covers the response cycle, set by
// the registered read of the slot memory. The receiver cannot stall.
// Reset clears write position, gop mark, fill count and key tracker; no clearing pass.
// Depends on srks_pkg and srks_ring_mem.
module sequence_ring_with_keyframe_search import srks_pkg::*; #(
	parameter int RING_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  srks_req_t req,
	output logic      busy,
	output logic      done,
	output srks_rsp_t rsp
);

	localparam int AW     = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int AGE_W  = $clog2(RING_DEPTH + 2);
	localparam logic [31:0]       DEPTH_W  = 32'(RING_DEPTH);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RING_DEPTH);
	localparam logic [AGE_W-1:0]  AGE_ONE  = AGE_W'(1);
	localparam logic [AGE_W-1:0]  AGE_LAST = AGE_W'(RING_DEPTH);
	localparam logic [AGE_W-1:0]  AGE_NONE = AGE_W'(RING_DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RESP = 1'b1;

	logic              state_q;
	logic [31:0]       wseq_q;
	logic [31:0]       gop_q;
	logic [FILL_W-1:0] fill_q;   // pushes since clear, saturating at depth
	logic [AGE_W-1:0]  age_q;    // distance back to newest key push, AGE_NONE if none within depth
	logic              rd_s1;
	logic [31:0]       idx_s1;

	logic        accept;
	srks_entry_t wr_entry;
	srks_entry_t rd_entry;
	logic [31:0] gap;
	logic        in_win;
	logic        hit;
	logic        key_found;

	assign accept = start && !busy;
	assign busy   = (state_q == ST_RESP);
	assign done   = (state_q == ST_RESP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wseq_q  <= '0;
			gop_q   <= '0;
			fill_q  <= '0;
			age_q   <= AGE_NONE;
		end else begin
			state_q <= accept ? ST_RESP : ST_IDLE;
			if (accept) begin
				case (req.opcode)
					OP_PUSH: begin
						wseq_q <= wseq_q + 32'd1;
						if (fill_q != FILL_MAX) begin
							fill_q <= fill_q + FILL_W'(1);
						end
						if (req.entry_is_key) begin
							age_q <= AGE_ONE;
						end else if (age_q != AGE_NONE) begin
							age_q <= age_q + AGE_W'(1);
						end
					end
					OP_MARK_GOP: begin
						gop_q <= req.position_index;
					end
					OP_CLEAR: begin
						wseq_q <= '0;
						gop_q  <= '0;
						fill_q <= '0;
						age_q  <= AGE_NONE;
					end
					OP_READ, OP_FIND_KEY: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1  <= (req.opcode == OP_READ);
			idx_s1 <= req.position_index;
		end
	end

	assign wr_entry = '{handle: req.entry_handle, is_key: req.entry_is_key};

	srks_ring_mem #(
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (accept && (req.opcode == OP_PUSH)),
		.wr_addr (wseq_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_en   (accept && (req.opcode == OP_READ)),
		.rd_addr (req.position_index[AW-1:0]),
		.rd_data (rd_entry)
	);

	// Status comes from the state after the operation; the memory data from the read.
	// A position inside the window is backed by a live slot once that many pushes
	// have landed since the last clear.
	always_comb begin
		gap       = wseq_q - idx_s1;
		in_win    = (gap != 32'd0) && (gap <= DEPTH_W);
		hit       = rd_s1 && in_win && (gap <= 32'(fill_q));
		key_found = (age_q <= AGE_LAST) && (32'(age_q) <= wseq_q);

		rsp.hit             = hit;
		rsp.handle_out      = hit ? rd_entry.handle : 32'd0;
		rsp.key_out         = hit && rd_entry.is_key;
		rsp.stale           = (gap != 32'd0) && (gap > DEPTH_W);
		rsp.write_position  = wseq_q;
		rsp.oldest_position = (wseq_q > DEPTH_W) ? (wseq_q - DEPTH_W) : 32'd0;
		rsp.key_start       = key_found ? (wseq_q - 32'(age_q)) : wseq_q;
		rsp.gop_mark        = gop_q;
	end

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request taken without a result");

	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_hit_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.hit) |-> !rsp.stale)
		else $error("hit reported on a stale index");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.hit) |-> ((rsp.handle_out == 32'd0) && !rsp.key_out))
		else $error("miss carries handle data");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		(age_q != AGE_NONE) |-> ((age_q >= AGE_ONE) && (age_q <= AGE_LAST)))
		else $error("key tracker out of range");

endmodule
